@@ hdl/nti_pkg.sv @@
// nti_pkg: shared constants, codes, types and helpers of the node table interpolator
// used by nti_store, nti_div and node_table_linear_interpolator; depends on nothing

package nti_pkg;

    localparam int DEPTH     = 256;
    localparam int AW        = 8;
    localparam int CW        = 9;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 49;
    localparam int DEN_W     = 33;
    localparam int QUO_W     = 50;
    localparam int DCNT_W    = 6;

    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) <<< FRAC_BITS;
    localparam logic [NUM_W-1:0] ONE_SQ = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // command codes
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_SINGLE = 3'd2;
    localparam logic [2:0] ST_RANGE  = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_PUT, S_INS, S_REM,
        S_Q0, S_QN, S_QB, S_QL, S_QR,
        S_DIVQ, S_WQ, S_WW, S_MULW, S_MUL1, S_MUL2, S_ADD, S_FIN, S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } t_div_rsp;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi_lim;
        logic signed [65:0] lo_lim;
        hi_lim = 66'(FX_MAX);
        lo_lim = 66'(FX_MIN);
        if (v > hi_lim) begin
            return FX_MAX;
        end else if (v < lo_lim) begin
            return FX_MIN;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

@@ hdl/nti_store.sv @@
// nti_store: node memory, x in the upper and y in the lower half of each word
// one write and one registered read per cycle; uses nti_pkg

module nti_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [nti_pkg::AW-1:0]        i_wa,
    input  logic [2*nti_pkg::DATA_W-1:0]  i_wd,
    input  logic [nti_pkg::AW-1:0]        i_ra,
    output logic [2*nti_pkg::DATA_W-1:0]  o_rd
);

    logic [2*nti_pkg::DATA_W-1:0] r_mem [nti_pkg::DEPTH];
    logic [2*nti_pkg::DATA_W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

@@ hdl/nti_div.sv @@
// nti_div: restoring divider, one quotient bit per cycle, signed result by magnitude
// truncates toward zero; uses nti_pkg

module nti_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nti_pkg::t_div_req i_req,
    output nti_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [nti_pkg::DCNT_W-1:0]    r_cnt;
    logic [nti_pkg::DEN_W-1:0]     r_rem;
    logic [nti_pkg::NUM_W-1:0]     r_quo;
    logic [nti_pkg::DEN_W-1:0]     r_den;
    logic                          r_neg;
    logic [nti_pkg::DEN_W:0]       trial;
    logic [nti_pkg::DEN_W:0]       diff;
    logic                          qbit;
    logic signed [nti_pkg::QUO_W-1:0] mag;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_quo[nti_pkg::NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= nti_pkg::DCNT_W'(nti_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - nti_pkg::DCNT_W'(1);
                if (r_cnt == nti_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[nti_pkg::DEN_W-1:0] : trial[nti_pkg::DEN_W-1:0];
            r_quo <= {r_quo[nti_pkg::NUM_W-2:0], qbit};
        end
    end

    assign mag        = $signed({1'b0, r_quo});
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -mag : mag;

endmodule

@@ hdl/node_table_linear_interpolator.sv @@
// node_table_linear_interpolator: table sequencer, shared multiplier and result register
// depends on nti_pkg, nti_store and nti_div

// One transaction at a time: o_in_ready is high only while the block is idle and the result
// is held until taken. Clear, append, unknown commands and rejected commands go straight
// from decode to the result. Insert and remove shift the nodes above the position one node
// per cycle through the node memory, which has one write and one read port. A query makes
// up to 12 memory reads for the end checks, bisection (at most 8 probes) and the bracketing
// pair, then two waits on the shared serial divider (49 quotient bits each; gradient, then
// right weight), then two passes through the shared 32x32 multiplier. Empty or single-node
// queries skip the search, and a zero step skips both divisions. Result back-pressure adds
// its stall cycles. After reset the table is empty.

module node_table_linear_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic [8:0]         i_position,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [7:0]         o_left_index,
    output logic [7:0]         o_right_index,
    output logic signed [31:0] o_weight_left,
    output logic signed [31:0] o_weight_right,
    output logic signed [31:0] o_grad_left,
    output logic signed [31:0] o_grad_right,
    output logic signed [31:0] o_interp_y,
    output logic [8:0]         o_node_count
);

    localparam int AW = nti_pkg::AW;
    localparam int CW = nti_pkg::CW;
    localparam int DW = nti_pkg::DATA_W;

    nti_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_lo, n_lo;
    logic [AW-1:0]   r_hi, n_hi;

    logic [2:0]            r_cmd;
    logic [CW-1:0]         r_pos;
    logic signed [DW-1:0]  r_xv, r_yv;
    logic signed [DW-1:0]  r_xl, r_yl, r_yr;
    logic signed [DW:0]    r_step, r_d;
    logic signed [nti_pkg::QUO_W-1:0] r_wr_full;
    logic signed [DW-1:0]  r_wl, r_wr, r_gl, r_gr, r_iy;
    logic signed [2*DW-1:0] r_prod, r_acc;
    logic signed [2*DW:0]  r_sum;
    logic [2:0]            r_status;
    logic [AW-1:0]         r_li, r_ri;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [2*DW-1:0]       mem_wd, mem_rd;
    logic signed [DW-1:0]  mem_x, mem_y;

    nti_pkg::t_div_req div_req;
    nti_pkg::t_div_rsp div_rsp;

    logic                  ins_bad, tbl_full;
    logic [CW-1:0]         cnt_m1, cnt_m2, idx_m1, idx_m2, idx_p1, idx_p2, pos_p1;
    logic [AW:0]           pair_sum, new_sum;
    logic [AW-1:0]         probe, nlo, nhi, lo_p1;
    logic [DW:0]           step_mag, d_mag;
    logic signed [DW-1:0]  mul_a, mul_b;
    logic signed [2*DW-1:0] mul_p;

    nti_store u_store (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    nti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mem_x = mem_rd[2*DW-1:DW];
    assign mem_y = mem_rd[DW-1:0];

    // helper arithmetic
    assign tbl_full = (r_count >= CW'(nti_pkg::DEPTH));
    assign ins_bad  = (r_count == '0) ? (r_pos != '0) : (r_pos >= r_count);
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign idx_m1   = r_idx - CW'(1);
    assign idx_m2   = r_idx - CW'(2);
    assign idx_p1   = r_idx + CW'(1);
    assign idx_p2   = r_idx + CW'(2);
    assign pos_p1   = r_pos + CW'(1);
    assign pair_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign probe    = pair_sum[AW:1];
    assign nlo      = (mem_x > r_xv) ? r_lo : probe;
    assign nhi      = (mem_x > r_xv) ? probe : r_hi;
    assign new_sum  = {1'b0, nlo} + {1'b0, nhi};
    assign lo_p1    = r_lo + AW'(1);
    assign step_mag = r_step[DW] ? (DW+1)'(0) - r_step : r_step;
    assign d_mag    = r_d[DW] ? (DW+1)'(0) - r_d : r_d;

    // shared multiplier
    assign mul_a = (r_state == nti_pkg::S_MUL1) ? r_yl : r_yr;
    assign mul_b = (r_state == nti_pkg::S_MUL1) ? r_wl : r_wr;
    assign mul_p = mul_a * mul_b;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nti_pkg::S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
        end
    end

    // sequencer: next state, memory and divider control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_lo    = r_lo;
        n_hi    = r_hi;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = {r_xv, r_yv};
        mem_ra  = '0;
        div_req = '0;
        unique case (r_state)
            nti_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = nti_pkg::S_DECODE;
                end
            end
            nti_pkg::S_DECODE: begin
                n_state = nti_pkg::S_DONE;
                priority if (r_cmd == nti_pkg::CMD_CLEAR) begin
                    n_count = '0;
                end else if (r_cmd == nti_pkg::CMD_APPEND) begin
                    if (!tbl_full) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end
                end else if (r_cmd == nti_pkg::CMD_INSERT) begin
                    if (!ins_bad && !tbl_full) begin
                        n_idx = r_count;
                        if (r_pos == r_count) begin
                            n_state = nti_pkg::S_PUT;
                        end else begin
                            mem_ra  = cnt_m1[AW-1:0];
                            n_state = nti_pkg::S_INS;
                        end
                    end
                end else if (r_cmd == nti_pkg::CMD_REMOVE) begin
                    if (r_pos < r_count) begin
                        n_idx = r_pos;
                        if (pos_p1 == r_count) begin
                            n_count = cnt_m1;
                        end else begin
                            mem_ra  = pos_p1[AW-1:0];
                            n_state = nti_pkg::S_REM;
                        end
                    end
                end else if (r_cmd == nti_pkg::CMD_QUERY) begin
                    if (r_count > CW'(1)) begin
                        mem_ra  = '0;
                        n_state = nti_pkg::S_Q0;
                    end
                end else begin
                    n_state = nti_pkg::S_DONE;
                end
            end
            nti_pkg::S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos[AW-1:0];
                n_count = r_count + CW'(1);
                n_state = nti_pkg::S_DONE;
            end
            nti_pkg::S_INS: begin
                // move one node up
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = mem_rd;
                n_idx  = idx_m1;
                if (idx_m1 == r_pos) begin
                    n_state = nti_pkg::S_PUT;
                end else begin
                    mem_ra = idx_m2[AW-1:0];
                end
            end
            nti_pkg::S_REM: begin
                // move one node down
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = mem_rd;
                n_idx  = idx_p1;
                if (idx_p2 == r_count) begin
                    n_count = cnt_m1;
                    n_state = nti_pkg::S_DONE;
                end else begin
                    mem_ra = idx_p2[AW-1:0];
                end
            end
            nti_pkg::S_Q0: begin
                if (r_xv < mem_x) begin
                    n_lo    = '0;
                    mem_ra  = '0;
                    n_state = nti_pkg::S_QL;
                end else begin
                    mem_ra  = cnt_m1[AW-1:0];
                    n_state = nti_pkg::S_QN;
                end
            end
            nti_pkg::S_QN: begin
                if (r_xv > mem_x) begin
                    n_lo    = cnt_m2[AW-1:0];
                    mem_ra  = cnt_m2[AW-1:0];
                    n_state = nti_pkg::S_QL;
                end else begin
                    n_lo = '0;
                    n_hi = cnt_m1[AW-1:0];
                    if (cnt_m1 > CW'(1)) begin
                        mem_ra  = cnt_m1[AW:1];
                        n_state = nti_pkg::S_QB;
                    end else begin
                        mem_ra  = '0;
                        n_state = nti_pkg::S_QL;
                    end
                end
            end
            nti_pkg::S_QB: begin
                // one bisection probe
                n_lo = nlo;
                n_hi = nhi;
                if ((nhi - nlo) > AW'(1)) begin
                    mem_ra = new_sum[AW:1];
                end else begin
                    mem_ra  = nlo;
                    n_state = nti_pkg::S_QL;
                end
            end
            nti_pkg::S_QL: begin
                mem_ra  = lo_p1;
                n_state = nti_pkg::S_QR;
            end
            nti_pkg::S_QR: begin
                n_state = nti_pkg::S_DIVQ;
            end
            nti_pkg::S_DIVQ: begin
                if (r_step == '0) begin
                    n_state = nti_pkg::S_MULW;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = nti_pkg::ONE_SQ;
                    div_req.den   = step_mag;
                    div_req.neg   = r_step[DW];
                    n_state       = nti_pkg::S_WQ;
                end
            end
            nti_pkg::S_WQ: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = {d_mag, {nti_pkg::FRAC_BITS{1'b0}}};
                    div_req.den   = step_mag;
                    div_req.neg   = r_d[DW] ^ r_step[DW];
                    n_state       = nti_pkg::S_WW;
                end
            end
            nti_pkg::S_WW: begin
                if (div_rsp.done) begin
                    n_state = nti_pkg::S_MULW;
                end
            end
            nti_pkg::S_MULW: n_state = nti_pkg::S_MUL1;
            nti_pkg::S_MUL1: n_state = nti_pkg::S_MUL2;
            nti_pkg::S_MUL2: n_state = nti_pkg::S_ADD;
            nti_pkg::S_ADD:  n_state = nti_pkg::S_FIN;
            nti_pkg::S_FIN:  n_state = nti_pkg::S_DONE;
            nti_pkg::S_DONE: begin
                if (i_out_ready) begin
                    n_state = nti_pkg::S_IDLE;
                end
            end
            default: n_state = nti_pkg::S_IDLE;
        endcase
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            nti_pkg::S_IDLE: begin
                r_cmd    <= i_cmd;
                r_pos    <= i_position;
                r_xv     <= i_x_value;
                r_yv     <= i_y_value;
                r_status <= nti_pkg::ST_OK;
                r_li     <= '0;
                r_ri     <= '0;
                r_wl     <= '0;
                r_wr     <= '0;
                r_gl     <= '0;
                r_gr     <= '0;
                r_iy     <= '0;
            end
            nti_pkg::S_DECODE: begin
                priority if (r_cmd == nti_pkg::CMD_APPEND) begin
                    if (tbl_full) begin
                        r_status <= nti_pkg::ST_FULL;
                    end
                end else if (r_cmd == nti_pkg::CMD_INSERT) begin
                    if (ins_bad) begin
                        r_status <= nti_pkg::ST_RANGE;
                    end else if (tbl_full) begin
                        r_status <= nti_pkg::ST_FULL;
                    end
                end else if (r_cmd == nti_pkg::CMD_REMOVE) begin
                    if (r_pos >= r_count) begin
                        r_status <= nti_pkg::ST_RANGE;
                    end
                end else if (r_cmd == nti_pkg::CMD_QUERY) begin
                    if (r_count == '0) begin
                        r_status <= nti_pkg::ST_EMPTY;
                    end else if (r_count == CW'(1)) begin
                        r_status <= nti_pkg::ST_SINGLE;
                        r_wl     <= nti_pkg::ONE_FX;
                    end
                end else begin
                    r_status <= nti_pkg::ST_OK;
                end
            end
            nti_pkg::S_QL: begin
                r_xl <= mem_x;
                r_yl <= mem_y;
            end
            nti_pkg::S_QR: begin
                r_yr   <= mem_y;
                r_step <= (DW+1)'(mem_x) - (DW+1)'(r_xl);
                r_d    <= (DW+1)'(r_xv) - (DW+1)'(r_xl);
            end
            nti_pkg::S_DIVQ: begin
                // duplicate nodes saturate the gradient
                if (r_step == '0) begin
                    r_gr      <= nti_pkg::FX_MAX;
                    r_gl      <= nti_pkg::FX_MIN;
                    r_wr_full <= '0;
                end
            end
            nti_pkg::S_WQ: begin
                if (div_rsp.done) begin
                    r_gr <= nti_pkg::sat32(66'(div_rsp.quo));
                    r_gl <= nti_pkg::sat32(-66'(div_rsp.quo));
                end
            end
            nti_pkg::S_WW: begin
                if (div_rsp.done) begin
                    r_wr_full <= div_rsp.quo;
                end
            end
            nti_pkg::S_MULW: begin
                r_wl <= nti_pkg::sat32(66'(nti_pkg::ONE_FX) - 66'(r_wr_full));
                r_wr <= nti_pkg::sat32(66'(r_wr_full));
            end
            nti_pkg::S_MUL1: begin
                r_prod <= mul_p;
            end
            nti_pkg::S_MUL2: begin
                r_prod <= mul_p;
                r_acc  <= r_prod;
            end
            nti_pkg::S_ADD: begin
                r_sum <= (2*DW+1)'(r_acc) + (2*DW+1)'(r_prod);
            end
            nti_pkg::S_FIN: begin
                r_iy <= nti_pkg::sat32(66'(r_sum >>> nti_pkg::FRAC_BITS));
                r_li <= r_lo;
                r_ri <= lo_p1;
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    // ports
    assign o_in_ready     = (r_state == nti_pkg::S_IDLE);
    assign o_out_valid    = (r_state == nti_pkg::S_DONE);
    assign o_status       = r_status;
    assign o_left_index   = r_li;
    assign o_right_index  = r_ri;
    assign o_weight_left  = r_wl;
    assign o_weight_right = r_wr;
    assign o_grad_left    = r_gl;
    assign o_grad_right   = r_gr;
    assign o_interp_y     = r_iy;
    assign o_node_count   = r_count;

`ifndef SYNTH
    // the table never holds more nodes than the memory has entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(nti_pkg::DEPTH))
        else $error("node count beyond table depth");

    // a successful query brackets with adjacent nodes
    a_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == nti_pkg::ST_OK && o_right_index != '0) |->
        (o_right_index == o_left_index + 8'd1))
        else $error("bracketing indices not adjacent");

    // a delivered result frees the input side on the next cycle
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("block not released after result transaction");
`endif

endmodule

@@ verif/testbench.sv @@
// testbench for node_table_linear_interpolator: directed and random command streams
// with a scoreboard that predicts every result; depends on nti_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         left_index;
        logic [7:0]         right_index;
        logic signed [31:0] weight_left;
        logic signed [31:0] weight_right;
        logic signed [31:0] grad_left;
        logic signed [31:0] grad_right;
        logic signed [31:0] interp_y;
        logic [8:0]         node_count;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_cmd = nti_pkg::CMD_CLEAR;
    logic [8:0]         i_position = '0;
    logic signed [31:0] i_x_value = '0;
    logic signed [31:0] i_y_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_status;
    logic [7:0]         o_left_index;
    logic [7:0]         o_right_index;
    logic signed [31:0] o_weight_left;
    logic signed [31:0] o_weight_right;
    logic signed [31:0] o_grad_left;
    logic signed [31:0] o_grad_right;
    logic signed [31:0] o_interp_y;
    logic [8:0]         o_node_count;

    int  mismatches = 0;
    int  items_sent = 0;
    int  queries_ok = 0;
    int  full_hits = 0;
    bit  gaps_on = 1'b1;

    node_table_linear_interpolator dut (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic mismatch_report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    class interp_scoreboard;
        int       nodes;
        int       xs[nti_pkg::DEPTH];
        int       ys[nti_pkg::DEPTH];
        t_result  pending[$];

        function new();
            nodes = 0;
            foreach (xs[k]) begin
                xs[k] = 0;
                ys[k] = 0;
            end
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // bracketing search, weights, gradients and blend for one query
        function void lookup(longint xv, ref t_result r);
            int     lft;
            int     lo;
            int     hi;
            int     mid;
            longint span;
            longint offset;
            longint q;
            longint wr;
            longint wl;
            longint p1;
            longint p2;
            longint h;
            longint frac_mask;
            frac_mask = (longint'(1) <<< nti_pkg::FRAC_BITS) - 1;
            if (nodes == 0) begin
                r.status = nti_pkg::ST_EMPTY;
                return;
            end
            if (nodes == 1) begin
                r.status = nti_pkg::ST_SINGLE;
                r.weight_left = nti_pkg::ONE_FX;
                return;
            end
            if (xv < longint'(xs[0])) begin
                lft = 0;
            end else if (xv > longint'(xs[nodes-1])) begin
                lft = nodes - 2;
            end else begin
                lo = 0;
                hi = nodes - 1;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (longint'(xs[mid]) > xv) hi = mid;
                    else lo = mid;
                end
                lft = lo;
            end
            span = longint'(xs[lft+1]) - longint'(xs[lft]);
            offset = xv - longint'(xs[lft]);
            if (span == 0) begin
                r.grad_right = nti_pkg::FX_MAX;
                r.grad_left = nti_pkg::FX_MIN;
                wr = 0;
            end else begin
                q = (longint'(1) <<< (2 * nti_pkg::FRAC_BITS)) / span;
                r.grad_right = 32'(clamp32(q));
                r.grad_left = 32'(clamp32(-q));
                wr = (offset * (longint'(1) <<< nti_pkg::FRAC_BITS)) / span;
            end
            wl = clamp32((longint'(1) <<< nti_pkg::FRAC_BITS) - wr);
            wr = clamp32(wr);
            p1 = longint'(ys[lft]) * wl;
            p2 = longint'(ys[lft+1]) * wr;
            // floor of each product plus the carry from the two fractions
            h = (p1 >>> nti_pkg::FRAC_BITS) + (p2 >>> nti_pkg::FRAC_BITS)
                + ((p1 & frac_mask) + (p2 & frac_mask)) / (longint'(1) <<< nti_pkg::FRAC_BITS);
            r.status = nti_pkg::ST_OK;
            r.left_index = 8'(lft);
            r.right_index = 8'(lft + 1);
            r.weight_left = 32'(wl);
            r.weight_right = 32'(wr);
            r.interp_y = 32'(clamp32(h));
        endfunction

        // note an accepted input transaction and queue its result
        function void note_input(logic [2:0] cmd, int pos, int xv, int yv);
            t_result r;
            r = '0;
            case (cmd)
                nti_pkg::CMD_CLEAR: nodes = 0;
                nti_pkg::CMD_APPEND: begin
                    if (nodes >= nti_pkg::DEPTH) begin
                        r.status = nti_pkg::ST_FULL;
                    end else begin
                        xs[nodes] = xv;
                        ys[nodes] = yv;
                        nodes++;
                    end
                end
                nti_pkg::CMD_INSERT: begin
                    if (nodes == 0 ? pos != 0 : pos >= nodes) begin
                        r.status = nti_pkg::ST_RANGE;
                    end else if (nodes >= nti_pkg::DEPTH) begin
                        r.status = nti_pkg::ST_FULL;
                    end else begin
                        for (int k = nodes; k > pos; k--) begin
                            xs[k] = xs[k-1];
                            ys[k] = ys[k-1];
                        end
                        xs[pos] = xv;
                        ys[pos] = yv;
                        nodes++;
                    end
                end
                nti_pkg::CMD_REMOVE: begin
                    if (pos >= nodes) begin
                        r.status = nti_pkg::ST_RANGE;
                    end else begin
                        for (int k = pos; k < nodes - 1; k++) begin
                            xs[k] = xs[k+1];
                            ys[k] = ys[k+1];
                        end
                        nodes--;
                    end
                end
                nti_pkg::CMD_QUERY: lookup(longint'(xv), r);
                default: ;
            endcase
            r.node_count = 9'(nodes);
            pending = {pending, r};
        endfunction

        // compare a result transaction with the oldest prediction
        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                mismatch_report("unexpected result", got.status, -1);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                mismatch_report("status", got.status, want.status);
            if (got.left_index != want.left_index)
                mismatch_report("left_index", got.left_index, want.left_index);
            if (got.right_index != want.right_index)
                mismatch_report("right_index", got.right_index, want.right_index);
            if (got.weight_left != want.weight_left)
                mismatch_report("weight_left", got.weight_left, want.weight_left);
            if (got.weight_right != want.weight_right)
                mismatch_report("weight_right", got.weight_right, want.weight_right);
            if (got.grad_left != want.grad_left)
                mismatch_report("grad_left", got.grad_left, want.grad_left);
            if (got.grad_right != want.grad_right)
                mismatch_report("grad_right", got.grad_right, want.grad_right);
            if (got.interp_y != want.interp_y)
                mismatch_report("interp_y", got.interp_y, want.interp_y);
            if (got.node_count != want.node_count)
                mismatch_report("node_count", got.node_count, want.node_count);
            if (want.status == nti_pkg::ST_OK && got.status == nti_pkg::ST_OK
                && want.right_index != 0)
                queries_ok++;
        endtask
    endclass

    interp_scoreboard sb = new();

    // result side: random back-pressure, check on each accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_status, o_left_index, o_right_index, o_weight_left,
                             o_weight_right, o_grad_left, o_grad_right, o_interp_y,
                             o_node_count});
        end
        i_out_ready <= !gaps_on || ($urandom_range(99) >= 12);
    end

    // drive one command and wait for its acceptance
    task automatic send_cmd(input logic [2:0] cmd, input int pos, input int xv, input int yv);
        if (gaps_on && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_position <= 9'(pos);
        i_x_value <= xv;
        i_y_value <= yv;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(cmd, pos, xv, yv);
        items_sent++;
        if (cmd == nti_pkg::CMD_APPEND && sb.pending[$].status == nti_pkg::ST_FULL) full_hits++;
    endtask

    // hold the sender until every result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // query x chosen near the stored nodes, between them or anywhere
    function automatic int pick_query_x();
        int k;
        if (sb.nodes == 0 || $urandom_range(9) == 0) return $urandom;
        k = $urandom_range(sb.nodes - 1);
        case ($urandom_range(3))
            0: return sb.xs[k];
            1: return sb.xs[k] + int'($urandom_range(255)) - 128;
            2: return k + 1 < sb.nodes ?
                      int'((longint'(sb.xs[k]) + longint'(sb.xs[k+1])) / 2) : sb.xs[k] + 1;
            default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    // clear, then build a non-decreasing set of nodes with random content
    task automatic build_nodes(input int size);
        longint cur;
        longint nxt;
        int     xv[$];
        send_cmd(nti_pkg::CMD_CLEAR, $urandom_range(511), $urandom, $urandom);
        cur = longint'(int'($urandom)) / ($urandom_range(1) ? 1 : 4096);
        for (int k = 0; k < size; k++) begin
            xv = {xv, int'(cur)};
            case ($urandom_range(9))
                0: nxt = cur;
                1, 2: nxt = cur + $urandom_range(7) + 1;
                3: nxt = cur + longint'($urandom);
                default: nxt = cur + $urandom_range(1 << 20);
            endcase
            cur = nxt > 64'sd2147483647 ? 64'sd2147483647 : nxt;
        end
        // either append in order or insert from the top down at the front
        if ($urandom_range(3) == 0 && size < 40) begin
            for (int k = size - 1; k >= 0; k--)
                send_cmd(nti_pkg::CMD_INSERT, 0, xv[k], $urandom);
        end else begin
            foreach (xv[k]) send_cmd(nti_pkg::CMD_APPEND, 0, xv[k], $urandom);
        end
    endtask

    initial begin
        int     size;
        int     wait_cycles;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, single node, unsorted, duplicates, extremes, bad positions
        send_cmd(nti_pkg::CMD_QUERY, 0, 0, 0);
        send_cmd(nti_pkg::CMD_REMOVE, 0, 0, 0);
        send_cmd(nti_pkg::CMD_INSERT, 1, 5, 5);
        send_cmd(nti_pkg::CMD_INSERT, 0, 32'sh00010000, 32'sh7FFFFFFF);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh7FFFFFFF, 0);
        send_cmd(nti_pkg::CMD_APPEND, 0, 32'sh7FFFFFFF, 32'sh80000000);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh80000000, 0);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh7FFFFFFF, 0);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh40000000, 0);
        send_cmd(nti_pkg::CMD_APPEND, 0, 32'sh80000000, 32'sh7FFFFFFF);
        send_cmd(nti_pkg::CMD_QUERY, 0, 0, 0);
        send_cmd(nti_pkg::CMD_CLEAR, 0, 0, 0);
        send_cmd(nti_pkg::CMD_APPEND, 0, 32'sh00020000, 32'sh00030000);
        send_cmd(nti_pkg::CMD_APPEND, 0, 32'sh00020000, -32'sh00050000);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh00020000, 0);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh00030000, 0);
        send_cmd(nti_pkg::CMD_APPEND, 0, 32'sh00020001, 32'sh7FFFFFFF);
        send_cmd(nti_pkg::CMD_QUERY, 0, 32'sh7FFFFFFF, 0);
        send_cmd(nti_pkg::CMD_INSERT, 511, 0, 0);
        send_cmd(nti_pkg::CMD_REMOVE, 256, 0, 0);
        send_cmd(nti_pkg::CMD_REMOVE, 1, 0, 0);
        send_cmd(3'd5, 0, 0, 0);
        send_cmd(3'd7, 511, -1, -1);
        drain_results();

        // random: tables of mostly small sizes, a few full ones, then mixed traffic
        while (items_sent < 1300) begin
            gaps_on = ($urandom_range(7) != 0);
            case ($urandom_range(19))
                0: size = nti_pkg::DEPTH;
                1: size = $urandom_range(1);
                2: size = $urandom_range(60, 13);
                default: size = $urandom_range(12, 2);
            endcase
            build_nodes(size);
            repeat ($urandom_range(14, 4)) begin
                case ($urandom_range(19))
                    0: send_cmd(nti_pkg::CMD_INSERT,
                                sb.nodes == 0 ? 0 : $urandom_range(sb.nodes - 1),
                                pick_query_x(), $urandom);
                    1: send_cmd(nti_pkg::CMD_REMOVE,
                                sb.nodes == 0 ? 0 : $urandom_range(sb.nodes - 1),
                                $urandom, $urandom);
                    2: send_cmd(3'($urandom_range(3, 2)), $urandom_range(511), $urandom,
                                $urandom);
                    3: send_cmd($urandom_range(1) ? nti_pkg::CMD_APPEND
                                                  : 3'($urandom_range(7, 5)),
                                $urandom_range(511), $urandom, $urandom);
                    4: if (sb.nodes == nti_pkg::DEPTH)
                           send_cmd(nti_pkg::CMD_INSERT, $urandom_range(nti_pkg::DEPTH - 1),
                                    $urandom, $urandom);
                       else
                           send_cmd(nti_pkg::CMD_QUERY, $urandom_range(511), $urandom,
                                    $urandom);
                    default: send_cmd(nti_pkg::CMD_QUERY, $urandom_range(511), pick_query_x(),
                                      $urandom);
                endcase
            end
            if ($urandom_range(9) == 0) drain_results();
        end
        i_in_valid <= 1'b0;

        // let the last results arrive, then a short quiet spell
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (400) @(posedge i_clk);
        if (sb.pending.size() != 0) mismatch_report("results never arrived", 0,
                                                    sb.pending.size());
        $display("covered %0d commands, %0d interpolating queries, %0d appends on a full set",
                 items_sent, queries_ok, full_hits);
        if (mismatches == 0) begin
            $display("node_table_linear_interpolator regression: pass");
        end else begin
            $display("node_table_linear_interpolator regression: fail");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #40_000_000;
        $display("node_table_linear_interpolator regression: fail");
        $finish;
    end

endmodule
